// ----- rtl/fbtr_pkg.sv -----
`timescale 1ns / 1ps
package fbtr_pkg;

  localparam int DisplayWidth    = 128;
  localparam int DisplayHeight   = 64;
  localparam int GlyphStoreDepth = 4096;

  localparam logic [7:0] SpaceCode = 8'd32;

  localparam logic [1:0] REG_FIRST_CODE  = 2'd0;
  localparam logic [1:0] REG_LAST_CODE   = 2'd1;
  localparam logic [1:0] REG_FONT_WIDTH  = 2'd2;
  localparam logic [1:0] REG_FONT_HEIGHT = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR, OP_PIXEL, OP_GLYPH, OP_LOAD, OP_READ, OP_CURSOR, OP_STRING, OP_CLEAN
  } op_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        ink;
    logic [7:0]  char_code;
    logic [11:0] glyph_addr;
    logic [7:0]  glyph_byte;
    logic [9:0]  fb_index;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       is_dirty;
    logic       text_stopped;
  } out_t;

  typedef struct packed {
    op_t op;
    in_t item;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [2:0] {
    ST_SWEEP, ST_IDLE, ST_PREP, ST_BASE, ST_ISSUE, ST_WRITE, ST_READ, ST_DONE
  } state_t;

endpackage

// ----- rtl/page_framebuffer_text_renderer.sv -----
`timescale 1ns / 1ps
// Steps: load, cursor, clean and a string char that draws nothing go from idle to done;
// read passes the read state, and a glyph off screen or of zero size the prep state. Clear
// sweeps every byte of the framebuffer. Pixel passes issue and write; a glyph passes prep and
// base, then one issue/write read-modify-write of the framebuffer memory per glyph pixel.
// One transaction at a time, the next starting the cycle after the result is popped; a
// 2-entry command queue decouples the sides. Reset clears all W*ceil(H/8) framebuffer bytes.
module page_framebuffer_text_renderer #(
  parameter int DISPLAY_WIDTH     = fbtr_pkg::DisplayWidth,
  parameter int DISPLAY_HEIGHT    = fbtr_pkg::DisplayHeight,
  parameter int GLYPH_STORE_DEPTH = fbtr_pkg::GlyphStoreDepth
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_data,
  input  logic            push,
  output logic            full,
  input  fbtr_pkg::in_t   cmd,
  output logic            empty,
  input  logic            pop,
  output fbtr_pkg::out_t  rsp
);

  fbtr_pkg::head_t head;
  logic            take;
  logic            hold;

  fbtr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .cmd  (cmd),
    .hold (hold),
    .head (head),
    .take (take)
  );

  fbtr_back #(
    .DISPLAY_WIDTH     (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT    (DISPLAY_HEIGHT),
    .GLYPH_STORE_DEPTH (GLYPH_STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .take      (take),
    .hold      (hold),
    .rsp       (rsp),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

// ----- rtl/fbtr_front.sv -----
`timescale 1ns / 1ps
module fbtr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  fbtr_pkg::in_t     cmd,
  input  logic              hold,
  output fbtr_pkg::head_t   head,
  input  logic              take
);

  fbtr_pkg::cmd_t slots [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_take;
  fbtr_pkg::op_t  op_dec;

  // classify the transaction by function code
  always_comb begin
    unique case (cmd.func)
      3'd0:    op_dec = fbtr_pkg::OP_CLEAR;
      3'd1:    op_dec = fbtr_pkg::OP_PIXEL;
      3'd2:    op_dec = fbtr_pkg::OP_GLYPH;
      3'd3:    op_dec = fbtr_pkg::OP_LOAD;
      3'd4:    op_dec = fbtr_pkg::OP_READ;
      3'd5:    op_dec = fbtr_pkg::OP_CURSOR;
      3'd6:    op_dec = fbtr_pkg::OP_STRING;
      default: op_dec = fbtr_pkg::OP_CLEAN;
    endcase
  end

  assign full       = (count == 2'd2) || hold;
  assign do_push    = push && !full;
  assign do_take    = take && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{op: op_dec, item: cmd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_take) rd_ptr <= ~rd_ptr;
      if (do_push && !do_take) count <= count + 2'd1;
      else if (!do_push && do_take) count <= count - 2'd1;
    end
  end

endmodule

// ----- rtl/fbtr_back.sv -----
`timescale 1ns / 1ps
module fbtr_back #(
  parameter int DISPLAY_WIDTH     = fbtr_pkg::DisplayWidth,
  parameter int DISPLAY_HEIGHT    = fbtr_pkg::DisplayHeight,
  parameter int GLYPH_STORE_DEPTH = fbtr_pkg::GlyphStoreDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data,
  input  fbtr_pkg::head_t  head,
  output logic             take,
  output logic             hold,
  output fbtr_pkg::out_t   rsp,
  output logic             empty,
  input  logic             pop
);

  localparam int FRAME_BYTES = DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8);
  localparam int FB_AW       = $clog2(FRAME_BYTES);
  localparam int GA_W        = $clog2(GLYPH_STORE_DEPTH);

  fbtr_pkg::state_t state, state_next;

  logic [7:0]  fb_mem [FRAME_BYTES];
  logic [7:0]  g_mem  [GLYPH_STORE_DEPTH];
  logic [7:0]  fb_rd;
  logic [7:0]  g_rd;
  logic        fb_we;
  logic [FB_AW-1:0] fb_wa;
  logic [FB_AW-1:0] fb_ra;
  logic [7:0]  fb_wd;
  logic        g_we;
  logic [GA_W-1:0] g_wa;
  logic [GA_W-1:0] g_ra;

  logic [7:0]  first_code, last_code;
  logic [4:0]  font_width;
  logic [5:0]  font_height;

  logic        dirty, stop;
  logic [7:0]  cursor_col, cursor_row, origin_col;
  logic        init;
  logic [FB_AW-1:0] sweep_cnt;
  logic        res_valid;

  fbtr_pkg::op_t op;
  logic        ink;
  logic        solid;
  logic        rd_ok;
  logic [9:0]  read_index;
  logic [7:0]  gx, gy;
  logic [7:0]  gidx;
  logic [4:0]  lw, col;
  logic [5:0]  lh, row;
  logic [7:0]  per_glyph;
  logic [16:0] col_base;
  logic [7:0]  page_off;

  logic        sweep_last;
  logic [7:0]  head_gidx;
  logic [7:0]  head_code;
  logic        s_active, s_wrap, s_stop;
  logic [7:0]  s_row, s_col;
  logic [8:0]  px, py;
  logic        pix_in;
  logic [15:0] pix_idx_full;
  logic [FB_AW-1:0] pix_idx;
  logic [16:0] gaddr_full;
  logic        bitval;
  logic [7:0]  bitmask;
  logic        last_pix;
  logic        corner_in;
  logic [3:0]  pages;

  function automatic logic [7:0] sat8(input logic [8:0] v);
    sat8 = v[8] ? 8'hFF : v[7:0];
  endfunction

  assign sweep_last = (sweep_cnt == FB_AW'(FRAME_BYTES - 1));
  assign take       = (state == fbtr_pkg::ST_IDLE) && head.valid && !res_valid;
  assign hold       = init;
  assign empty      = !res_valid;

  // substitute space for codes outside the loaded range
  assign head_code = (head.cmd.item.char_code < first_code ||
                      head.cmd.item.char_code > last_code) ? fbtr_pkg::SpaceCode
                                                           : head.cmd.item.char_code;
  assign head_gidx = head_code - first_code;

  // string cursor: wrap, then bottom check
  assign s_active = !stop && (head.cmd.item.char_code != 8'd0);
  assign s_wrap   = (9'(cursor_col) + 9'(font_width)) > 9'(DISPLAY_WIDTH);
  assign s_row    = s_wrap ? sat8(9'(cursor_row) + 9'(font_height)) : cursor_row;
  assign s_col    = s_wrap ? origin_col : cursor_col;
  assign s_stop   = (9'(s_row) + 9'(font_height)) > 9'(DISPLAY_HEIGHT);

  assign px           = 9'(gx) + 9'(col);
  assign py           = 9'(gy) + 9'(row);
  assign pix_in       = (px < 9'(DISPLAY_WIDTH)) && (py < 9'(DISPLAY_HEIGHT));
  assign pix_idx_full = 16'(px) + 16'(py[8:3]) * 16'(DISPLAY_WIDTH);
  assign pix_idx      = pix_idx_full[FB_AW-1:0];
  assign gaddr_full   = col_base + 17'(page_off);
  assign bitval       = solid ? ink : (g_rd[row[2:0]] ? ink : ~ink);
  assign bitmask      = 8'b1 << py[2:0];
  assign last_pix     = (row == lh - 6'd1) && (col == lw - 5'd1);
  assign corner_in    = (9'(gx) < 9'(DISPLAY_WIDTH)) && (9'(gy) < 9'(DISPLAY_HEIGHT));
  assign pages        = 4'((7'(lh) + 7'd7) >> 3);

  always_comb begin
    state_next = state;
    unique case (state)
      fbtr_pkg::ST_SWEEP: if (sweep_last) state_next = init ? fbtr_pkg::ST_IDLE
                                                            : fbtr_pkg::ST_DONE;
      fbtr_pkg::ST_IDLE: begin
        if (take) begin
          unique case (head.cmd.op)
            fbtr_pkg::OP_CLEAR:  state_next = fbtr_pkg::ST_SWEEP;
            fbtr_pkg::OP_PIXEL:  state_next = fbtr_pkg::ST_ISSUE;
            fbtr_pkg::OP_GLYPH:  state_next = fbtr_pkg::ST_PREP;
            fbtr_pkg::OP_READ:   state_next = fbtr_pkg::ST_READ;
            fbtr_pkg::OP_STRING: state_next = (s_active && !s_stop) ? fbtr_pkg::ST_PREP
                                                                    : fbtr_pkg::ST_DONE;
            default:             state_next = fbtr_pkg::ST_DONE;
          endcase
        end
      end
      fbtr_pkg::ST_PREP:  state_next = (!corner_in || lw == 5'd0 || lh == 6'd0)
                                       ? fbtr_pkg::ST_DONE : fbtr_pkg::ST_BASE;
      fbtr_pkg::ST_BASE:  state_next = fbtr_pkg::ST_ISSUE;
      fbtr_pkg::ST_ISSUE: state_next = fbtr_pkg::ST_WRITE;
      fbtr_pkg::ST_WRITE: state_next = last_pix ? fbtr_pkg::ST_DONE : fbtr_pkg::ST_ISSUE;
      fbtr_pkg::ST_READ:  state_next = fbtr_pkg::ST_DONE;
      fbtr_pkg::ST_DONE:  state_next = fbtr_pkg::ST_IDLE;
      default:            state_next = fbtr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fb_we = 1'b0;
    fb_wa = sweep_cnt;
    fb_wd = 8'd0;
    fb_ra = pix_idx;
    g_we  = 1'b0;
    g_wa  = GA_W'(head.cmd.item.glyph_addr);
    g_ra  = gaddr_full[GA_W-1:0];
    unique case (state)
      fbtr_pkg::ST_SWEEP: fb_we = 1'b1;
      fbtr_pkg::ST_IDLE:  g_we = take && (head.cmd.op == fbtr_pkg::OP_LOAD);
      fbtr_pkg::ST_WRITE: begin
        fb_we = pix_in;
        fb_wa = pix_idx;
        fb_wd = bitval ? (fb_rd | bitmask) : (fb_rd & ~bitmask);
      end
      fbtr_pkg::ST_READ:  fb_ra = FB_AW'(read_index);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb_mem[fb_wa] <= fb_wd;
    fb_rd <= fb_mem[fb_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) g_mem[g_wa] <= head.cmd.item.glyph_byte;
    g_rd <= g_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= fbtr_pkg::ST_SWEEP;
      init        <= 1'b1;
      sweep_cnt   <= '0;
      res_valid   <= 1'b0;
      dirty       <= 1'b1;
      stop        <= 1'b0;
      cursor_col  <= 8'd0;
      cursor_row  <= 8'd0;
      origin_col  <= 8'd0;
      first_code  <= 8'd32;
      last_code   <= 8'd126;
      font_width  <= 5'd6;
      font_height <= 6'd8;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          fbtr_pkg::REG_FIRST_CODE:  first_code  <= cfg_data;
          fbtr_pkg::REG_LAST_CODE:   last_code   <= cfg_data;
          fbtr_pkg::REG_FONT_WIDTH:  font_width  <= cfg_data[4:0];
          fbtr_pkg::REG_FONT_HEIGHT: font_height <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (pop && res_valid) res_valid <= 1'b0;
      unique case (state)
        fbtr_pkg::ST_SWEEP: begin
          sweep_cnt <= sweep_last ? '0 : sweep_cnt + 1'b1;
          if (sweep_last) init <= 1'b0;
        end
        fbtr_pkg::ST_IDLE: begin
          if (take) begin
            unique case (head.cmd.op)
              fbtr_pkg::OP_CLEAR:  dirty <= 1'b1;
              fbtr_pkg::OP_CURSOR: begin
                cursor_col <= head.cmd.item.pos_x;
                origin_col <= head.cmd.item.pos_x;
                cursor_row <= head.cmd.item.pos_y;
                stop       <= 1'b0;
              end
              fbtr_pkg::OP_STRING: begin
                dirty <= 1'b1;
                if (s_active) begin
                  cursor_row <= s_row;
                  stop       <= s_stop;
                  cursor_col <= s_stop ? s_col : sat8(9'(s_col) + 9'(font_width));
                end
              end
              fbtr_pkg::OP_CLEAN:  dirty <= 1'b0;
              default: ;
            endcase
          end
        end
        fbtr_pkg::ST_PREP: begin
          per_glyph <= 8'(lw) * 8'(pages);
          if (corner_in) dirty <= 1'b1;
        end
        fbtr_pkg::ST_WRITE: begin
          if (pix_in) dirty <= 1'b1;
        end
        fbtr_pkg::ST_DONE: res_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // transaction payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      op         <= head.cmd.op;
      ink        <= head.cmd.item.ink;
      gidx       <= head_gidx;
      read_index <= head.cmd.item.fb_index;
      rd_ok      <= 32'(head.cmd.item.fb_index) < 32'(FRAME_BYTES);
      col        <= 5'd0;
      row        <= 6'd0;
      col_base   <= 17'd0;
      page_off   <= 8'd0;
      solid      <= (head.cmd.op == fbtr_pkg::OP_PIXEL);
      lw         <= (head.cmd.op == fbtr_pkg::OP_PIXEL) ? 5'd1 : font_width;
      lh         <= (head.cmd.op == fbtr_pkg::OP_PIXEL) ? 6'd1 : font_height;
      if (head.cmd.op == fbtr_pkg::OP_STRING) begin
        gx <= s_col;
        gy <= s_row;
      end else begin
        gx <= head.cmd.item.pos_x;
        gy <= head.cmd.item.pos_y;
      end
    end else if (state == fbtr_pkg::ST_BASE) begin
      col_base <= 17'(gidx) * 17'(per_glyph);
    end else if (state == fbtr_pkg::ST_WRITE) begin
      // advance row within a column, then step to the next column
      if (row == lh - 6'd1) begin
        row      <= 6'd0;
        page_off <= 8'd0;
        col      <= col + 5'd1;
        col_base <= col_base + 17'd1;
      end else begin
        row <= row + 6'd1;
        if (row[2:0] == 3'd7) page_off <= page_off + 8'(lw);
      end
    end
    if (state == fbtr_pkg::ST_DONE) begin
      rsp.read_data    <= (op == fbtr_pkg::OP_READ && rd_ok) ? fb_rd : 8'd0;
      rsp.is_dirty     <= dirty;
      rsp.text_stopped <= stop;
    end
  end

endmodule

// ----- sim/tb_page_framebuffer_text_renderer.sv -----
`timescale 1ns / 1ps
module tb_page_framebuffer_text_renderer;

  localparam int DispW      = fbtr_pkg::DisplayWidth;
  localparam int DispH      = fbtr_pkg::DisplayHeight;
  localparam int GDepth     = fbtr_pkg::GlyphStoreDepth;
  localparam int FbBytes    = DispW * ((DispH + 7) / 8);
  localparam int CycleCap   = 3000000;
  localparam int PhaseItems = 70;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = '0;
  logic [7:0]     cfg_data = '0;
  logic           push = 1'b0;
  logic           full;
  fbtr_pkg::in_t  cmd = '0;
  logic           empty;
  logic           pop = 1'b0;
  fbtr_pkg::out_t rsp;

  page_framebuffer_text_renderer i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .cmd(cmd), .empty(empty), .pop(pop), .rsp(rsp)
  );

  always #5 clk = ~clk;

  // shadow of the block state
  logic [7:0] fb_mem [FbBytes];
  logic [7:0] glyph_mem [GDepth];
  bit         glyph_loaded [GDepth];
  bit         dirty_q, stopped_q;
  int         cur_col, cur_row, org_col;
  int         first_code, last_code, font_w, font_h;

  fbtr_pkg::out_t expected_rsp [$];
  int   mismatches = 0;
  int   cycles = 0;
  int   items_sent = 0;
  bit   idle_en = 1'b1;
  int   pop_stall = 0;

  function automatic int glyph_base(int code);
    int c;
    int gidx;
    c = (code < first_code || code > last_code) ? int'(fbtr_pkg::SpaceCode) : code;
    gidx = (c - first_code) & 'hFF;
    return gidx * font_w * ((font_h + 7) / 8);
  endfunction

  function automatic void plot(int x, int y, bit on);
    int idx;
    if (x >= DispW || y >= DispH) return;
    idx = x + (y / 8) * DispW;
    fb_mem[idx][y % 8] = on;
    dirty_q = 1'b1;
  endfunction

  function automatic void blit(int x, int y, int code, bit on);
    int base;
    int a;
    bit b;
    if (x >= DispW || y >= DispH) return;
    base = glyph_base(code);
    for (int col = 0; col < font_w; col++)
      for (int row = 0; row < font_h; row++) begin
        a = (base + col + (row / 8) * font_w) % GDepth;
        b = glyph_mem[a][row % 8];
        plot(x + col, y + row, b ? on : ~on);
      end
    dirty_q = 1'b1;
  endfunction

  function automatic int sat8(int v);
    return v > 255 ? 255 : v;
  endfunction

  function automatic fbtr_pkg::out_t render_step(fbtr_pkg::in_t it);
    fbtr_pkg::out_t r;
    r = '0;
    case (fbtr_pkg::op_t'(it.func))
      fbtr_pkg::OP_CLEAR: begin
        foreach (fb_mem[i]) fb_mem[i] = '0;
        dirty_q = 1'b1;
      end
      fbtr_pkg::OP_PIXEL: plot(int'(it.pos_x), int'(it.pos_y), it.ink);
      fbtr_pkg::OP_GLYPH: blit(int'(it.pos_x), int'(it.pos_y), int'(it.char_code), it.ink);
      fbtr_pkg::OP_LOAD: begin
        glyph_mem[int'(it.glyph_addr) % GDepth] = it.glyph_byte;
        glyph_loaded[int'(it.glyph_addr) % GDepth] = 1'b1;
      end
      fbtr_pkg::OP_READ: if (int'(it.fb_index) < FbBytes) r.read_data = fb_mem[it.fb_index];
      fbtr_pkg::OP_CURSOR: begin
        cur_col = int'(it.pos_x);
        org_col = int'(it.pos_x);
        cur_row = int'(it.pos_y);
        stopped_q = 1'b0;
      end
      fbtr_pkg::OP_STRING: begin
        if (!stopped_q && it.char_code != 8'd0) begin
          if (cur_col + font_w > DispW) begin
            cur_col = org_col;
            cur_row = sat8(cur_row + font_h);
          end
          if (cur_row + font_h > DispH) stopped_q = 1'b1;
          else begin
            blit(cur_col, cur_row, int'(it.char_code), it.ink);
            cur_col = sat8(cur_col + font_w);
          end
        end
        dirty_q = 1'b1;
      end
      default: dirty_q = 1'b0;
    endcase
    r.is_dirty = dirty_q;
    r.text_stopped = stopped_q;
    return r;
  endfunction

  // push stays high after acceptance; drain() lowers it in the same step
  task automatic send_item(fbtr_pkg::in_t it);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= it;
    do @(posedge clk); while (full);
    items_sent++;
    expected_rsp.push_back(render_step(it));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      fbtr_pkg::REG_FIRST_CODE: first_code = int'(val);
      fbtr_pkg::REG_LAST_CODE:  last_code = int'(val);
      fbtr_pkg::REG_FONT_WIDTH: font_w = int'(val) & 'h1F;
      default:                  font_h = int'(val) & 'h3F;
    endcase
  endtask

  task automatic set_font(int fc, int lc, int w, int h);
    drain();
    write_reg(fbtr_pkg::REG_FIRST_CODE, 8'(fc));
    write_reg(fbtr_pkg::REG_LAST_CODE, 8'(lc));
    write_reg(fbtr_pkg::REG_FONT_WIDTH, 8'(w));
    write_reg(fbtr_pkg::REG_FONT_HEIGHT, 8'(h));
    cfg_we <= 1'b0;
  endtask

  function automatic fbtr_pkg::in_t rand_item(fbtr_pkg::op_t op);
    fbtr_pkg::in_t it;
    logic [63:0]   rnd;
    rnd = {$urandom, $urandom};
    it = rnd[$bits(fbtr_pkg::in_t)-1:0];
    it.func = op;
    if ($urandom_range(0, 4) != 0) begin
      it.pos_x = 8'($urandom_range(0, DispW - 1));
      it.pos_y = 8'($urandom_range(0, DispH - 1));
    end
    return it;
  endfunction

  // fill every glyph byte the code would fetch so nothing undefined is read
  task automatic preload_glyph(int code);
    int base;
    int a;
    fbtr_pkg::in_t ld;
    base = glyph_base(code);
    for (int col = 0; col < font_w; col++)
      for (int row = 0; row < font_h; row += 8) begin
        a = (base + col + (row / 8) * font_w) % GDepth;
        if (!glyph_loaded[a]) begin
          ld = rand_item(fbtr_pkg::OP_LOAD);
          ld.glyph_addr = 12'(a);
          send_item(ld);
        end
      end
  endtask

  task automatic send_op(fbtr_pkg::op_t op, int x, int y, int code, bit ink);
    fbtr_pkg::in_t it;
    it = rand_item(op);
    it.pos_x = 8'(x);
    it.pos_y = 8'(y);
    it.char_code = 8'(code);
    it.ink = ink;
    if (op == fbtr_pkg::OP_GLYPH || op == fbtr_pkg::OP_STRING) preload_glyph(code);
    send_item(it);
  endtask

  task automatic send_read(int idx);
    fbtr_pkg::in_t it;
    it = rand_item(fbtr_pkg::OP_READ);
    it.fb_index = 10'(idx);
    send_item(it);
  endtask

  task automatic test_pixels();
    send_op(fbtr_pkg::OP_CLEAN, 0, 0, 0, 0);
    send_op(fbtr_pkg::OP_PIXEL, 0, 0, 0, 1);
    send_op(fbtr_pkg::OP_PIXEL, 127, 63, 0, 1);
    send_op(fbtr_pkg::OP_PIXEL, 128, 0, 0, 1);
    send_op(fbtr_pkg::OP_PIXEL, 255, 255, 0, 1);
    send_read(0);
    send_read(FbBytes - 1);
    send_op(fbtr_pkg::OP_PIXEL, 0, 0, 0, 0);
    send_read(0);
    send_op(fbtr_pkg::OP_CLEAR, 0, 0, 0, 0);
    send_read(FbBytes - 1);
  endtask

  task automatic test_glyphs();
    fbtr_pkg::in_t ld;
    ld = rand_item(fbtr_pkg::OP_LOAD);
    ld.glyph_addr = 12'(GDepth - 1);
    send_item(ld);
    send_op(fbtr_pkg::OP_GLYPH, 0, 0, 65, 1);
    send_op(fbtr_pkg::OP_GLYPH, 125, 60, 66, 0);
    send_op(fbtr_pkg::OP_GLYPH, 200, 10, 67, 1);
    send_op(fbtr_pkg::OP_GLYPH, 10, 20, 200, 1);
    send_read(125 + 7 * DispW);
  endtask

  task automatic test_text();
    send_op(fbtr_pkg::OP_CURSOR, 116, 48, 0, 0);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 72, 1);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 0, 1);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 73, 1);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 74, 1);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 75, 1);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 76, 1);
    send_op(fbtr_pkg::OP_CURSOR, 250, 250, 0, 0);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 77, 0);
    send_op(fbtr_pkg::OP_CLEAN, 0, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    set_font(0, 255, 16, 32);
    send_op(fbtr_pkg::OP_GLYPH, 120, 40, 255, 1);
    send_op(fbtr_pkg::OP_CURSOR, 100, 0, 0, 0);
    repeat (4) send_op(fbtr_pkg::OP_STRING, 0, 0, 255, 1);
    set_font(200, 100, 1, 1);
    send_op(fbtr_pkg::OP_GLYPH, 5, 5, 150, 1);
    send_op(fbtr_pkg::OP_CURSOR, 126, 62, 0, 0);
    repeat (4) send_op(fbtr_pkg::OP_STRING, 0, 0, 33, 1);
    set_font(255, 255, 0, 0);
    send_op(fbtr_pkg::OP_CLEAN, 0, 0, 0, 0);
    send_op(fbtr_pkg::OP_GLYPH, 3, 3, 255, 1);
    send_op(fbtr_pkg::OP_STRING, 0, 0, 255, 1);
    set_font(32, 126, 6, 8);
  endtask

  task automatic test_random();
    int start;
    int k;
    int w;
    int h;
    for (int phase = 0; phase < 5; phase++) begin
      idle_en = (phase != 4);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
      set_font($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 32,
               $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : 126, w, h);
      start = items_sent;
      while (items_sent - start < PhaseItems) begin
        if ($urandom_range(0, 4) == 0) begin
          k = $urandom_range(3, 25);
          send_op(fbtr_pkg::OP_CURSOR, $urandom_range(0, 140), $urandom_range(0, 70), 0, 0);
          repeat (k)
            if (items_sent - start < PhaseItems)
              send_op(fbtr_pkg::OP_STRING, 0, 0,
                      $urandom_range(0, 15) == 0 ? 0 : $urandom_range(1, 255),
                      $urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 9))
            0: send_op(fbtr_pkg::OP_CLEAR, 0, 0, 0, 0);
            1, 2: send_item(rand_item(fbtr_pkg::OP_PIXEL));
            3: send_op(fbtr_pkg::OP_GLYPH, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 1));
            4: send_item(rand_item(fbtr_pkg::OP_LOAD));
            5, 6, 7: send_item(rand_item(fbtr_pkg::OP_READ));
            8: send_op(fbtr_pkg::OP_CLEAN, 0, 0, 0, 0);
            default: send_op(fbtr_pkg::OP_GLYPH, $urandom_range(0, 127), $urandom_range(0, 63),
                             $urandom_range(0, 255), $urandom_range(0, 1));
          endcase
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (pop_stall > 0) begin
      pop <= 1'b0;
      pop_stall <= pop_stall - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      pop <= 1'b0;
      pop_stall <= $urandom_range(0, 10);
    end else begin
      pop <= 1'b1;
    end
    if (!rst && pop && !empty) begin
      if (expected_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", rsp);
      end else begin
        if (rsp.read_data !== expected_rsp[0].read_data
            || rsp.is_dirty !== expected_rsp[0].is_dirty
            || rsp.text_stopped !== expected_rsp[0].text_stopped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected data %h dirty %b stopped %b, got %h %b %b",
                     expected_rsp[0].read_data, expected_rsp[0].is_dirty,
                     expected_rsp[0].text_stopped, rsp.read_data, rsp.is_dirty,
                     rsp.text_stopped);
        end
        void'(expected_rsp.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleCap) begin
      $display("tb_page_framebuffer_text_renderer NOT OK");
      $finish;
    end
  end

  initial begin
    foreach (fb_mem[i]) fb_mem[i] = '0;
    foreach (glyph_mem[i]) begin
      glyph_mem[i] = '0;
      glyph_loaded[i] = 1'b0;
    end
    dirty_q = 1'b1;
    stopped_q = 1'b0;
    cur_col = 0;
    cur_row = 0;
    org_col = 0;
    first_code = 32;
    last_code = 126;
    font_w = 6;
    font_h = 8;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (full) @(posedge clk);
    test_pixels();
    test_glyphs();
    test_text();
    test_config_extremes();
    test_random();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_rsp.size() == 0)
      $display("tb_page_framebuffer_text_renderer OK");
    else
      $display("tb_page_framebuffer_text_renderer NOT OK");
    $finish;
  end

endmodule
